// File: hw/rtl/deferred_event_timer_table_macros.svh
// Assertion macros for the deferred event timer table
`ifndef DEFERRED_EVENT_TIMER_TABLE_MACROS_SVH
`define DEFERRED_EVENT_TIMER_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define DETT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DETT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DETT_ASSERT_SAME(lbl, ante, cons)
`define DETT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/dett_pkg.sv
// Types and constants of the deferred event timer table
package dett_pkg;
	localparam int DEPTH = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = IDX_W + 1;
	localparam int IN_W = 136;
	localparam int OUT_W = 104;

	localparam logic [2:0] OP_ADVANCE = 3'd0;
	localparam logic [2:0] OP_SCHED_ONCE = 3'd1;
	localparam logic [2:0] OP_SCHED_REP = 3'd2;
	localparam logic [2:0] OP_CANCEL = 3'd3;
	localparam logic [2:0] OP_PAUSE = 3'd4;
	localparam logic [2:0] OP_RESUME = 3'd5;
	localparam logic [2:0] OP_QUERY = 3'd6;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic        present;
		logic [15:0] fire_count;
		logic [31:0] fired_payload;
		logic [15:0] fired_event;
		logic [31:0] result_id;
		logic [1:0]  status;
	} res_t;

	typedef struct packed {
		logic        repeating;
		logic [15:0] event_code;
		logic [31:0] payload;
		logic [31:0] due;
		logic [15:0] interval;
		logic [15:0] remaining;
	} rec_t;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_SINGLE = 9'b000000010,
		S_RANK   = 9'b000000100,
		S_READ   = 9'b000001000,
		S_CHECK  = 9'b000010000,
		S_DIV    = 9'b000100000,
		S_UPD    = 9'b001000000,
		S_PUSH   = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;
endpackage

// File: hw/rtl/deferred_event_timer_table.sv
// Deferred event timer table: timer list with one-shot and repeating tasks
//
//  channel | dir | tdata fields (low bit up)                                  | tlast
//  s_axis  | in  | operation, time_step, delay, repeat_count, task_id,       | -
//          |     | event_code, payload                                        |
//  m_axis  | out | status, result_id, fired_event, fired_payload, fire_count, | last
//          |     | present                                                    |
//
// One item at a time. Non-advance requests pass through SINGLE, waiting for the output register.
// Advance: rank all 16 slots, then read and check each live task; a firing repeating
// task with a nonzero interval runs a 32-step divider and an update, and every firing
// task is pushed; a closing state ends it, and output waits can stall push and close.
// Slot records sit in one synchronous memory; ids, valid and pause bits in flops.
// Reset clears valid and pause bits and clock, sets the id counter to 1; no clearing pass.
// A request is taken while an earlier result still waits in the output register.
module deferred_event_timer_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// operation, time_step, delay, repeat_count, task_id, event_code, payload
	input  logic [dett_pkg::IN_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// status, result_id, fired_event, fired_payload, fire_count, present
	output logic [dett_pkg::OUT_W-1:0] m_axis_tdata,
	output logic                       m_axis_tlast
);
	import dett_pkg::*;
	`include "deferred_event_timer_table_macros.svh"

	state_t            state_q;
	logic [2:0]        op_q;
	logic [15:0]       delay_q, rcount_q, ev_q;
	logic [31:0]       tid_q, pl_q;
	logic [31:0]       clock_q, next_id_q;
	logic [DEPTH-1:0]  valid_q, paused_q;
	logic [31:0]       id_q [DEPTH];
	logic [IDX_W-1:0]  order_q [DEPTH];
	logic [CNT_W-1:0]  cnt_q, nvalid_q;
	logic [IDX_W-1:0]  cur_q;
	logic [31:0]       dq_q, quo_q;
	logic [16:0]       rem_q;
	logic [4:0]        dcnt_q;
	res_t              new_q, hold_q, out_q;
	logic              hold_v_q, out_v_q, out_last_q;

	rec_t              mem_q [DEPTH];
	rec_t              rd_q, wr_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr, rd_addr;

	logic              accept, out_free, out_load;
	logic [2:0]        in_op;
	logic [15:0]       in_step;
	logic [32:0]       clk_sum;
	logic [IDX_W-1:0]  cidx;
	logic [31:0]       id_c;
	logic [DEPTH-1:0]  lt_vec, hit_vec;
	logic [CNT_W-1:0]  rank;
	logic              found, full;
	logic [IDX_W-1:0]  hit_idx, free_idx;
	logic [32:0]       sch_due;
	logic              due_ok;
	logic [16:0]       rem_sh;
	logic              rem_ge;
	logic [32:0]       q33, fired33;
	logic              limited, dies;
	logic [15:0]       newrm, cnt16;
	logic [32:0]       upd_due;
	logic [31:0]       nid_inc;
	res_t              single_res;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign out_free = !out_v_q || m_axis_tready;
	assign out_load = out_free && (state_q == S_SINGLE || state_q == S_FINISH ||
		(state_q == S_PUSH && hold_v_q));
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {5'b0, out_q};
	assign m_axis_tlast = out_last_q;

	assign in_op = s_axis_tdata[2:0];
	assign in_step = s_axis_tdata[18:3];
	assign clk_sum = {1'b0, clock_q} + {17'b0, in_step};

	assign cidx = cnt_q[IDX_W-1:0];
	assign id_c = id_q[cidx];

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			lt_vec[j] = valid_q[j] && ((id_q[j] < id_c) ||
				((id_q[j] == id_c) && (IDX_W'(j) < cidx)));
			hit_vec[j] = valid_q[j] && (id_q[j] == tid_q);
		end
		rank = CNT_W'($countones(lt_vec));
		found = |hit_vec;
		full = &valid_q;
		hit_idx = '0;
		free_idx = '0;
		for (int j = DEPTH - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_idx = IDX_W'(j);
			end
			if (!valid_q[j]) begin
				free_idx = IDX_W'(j);
			end
		end
	end

	assign sch_due = {1'b0, clock_q} + {17'b0, delay_q};
	assign due_ok = clock_q >= rd_q.due;
	assign rem_sh = {rem_q[15:0], dq_q[31]};
	assign rem_ge = rem_sh >= {1'b0, rd_q.interval};

	always_comb begin
		q33 = {1'b0, quo_q} + 33'd1;
		limited = rd_q.remaining != 16'd0;
		fired33 = q33;
		if (limited && (q33 > {17'b0, rd_q.remaining})) begin
			fired33 = {17'b0, rd_q.remaining};
		end
		newrm = rd_q.remaining - fired33[15:0];
		dies = limited && (newrm == 16'd0);
		cnt16 = (fired33 > 33'h0FFFF) ? 16'hFFFF : fired33[15:0];
		upd_due = {1'b0, clock_q} - {17'b0, rem_q[15:0]} + {17'b0, rd_q.interval};
		nid_inc = next_id_q + 32'd1;
	end

	always_comb begin
		single_res = '0;
		unique case (op_q)
			OP_ADVANCE: begin
				single_res = '0;
			end
			OP_SCHED_ONCE, OP_SCHED_REP: begin
				if (full) begin
					single_res.status = ST_FULL;
				end else begin
					single_res.result_id = next_id_q;
				end
			end
			OP_CANCEL, OP_PAUSE, OP_RESUME, OP_QUERY: begin
				if (!found) begin
					single_res.status = ST_NOT_FOUND;
				end else begin
					single_res.present = (op_q == OP_QUERY);
				end
			end
			default: begin
				single_res = '0;
			end
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cur_q;
		wr_data = rd_q;
		rd_addr = order_q[cidx];
		if (state_q == S_SINGLE && out_free && !full &&
			(op_q == OP_SCHED_ONCE || op_q == OP_SCHED_REP)) begin
			wr_en = 1'b1;
			wr_addr = free_idx;
			wr_data.repeating = (op_q == OP_SCHED_REP);
			wr_data.event_code = ev_q;
			wr_data.payload = pl_q;
			wr_data.due = sch_due[32] ? 32'hFFFFFFFF : sch_due[31:0];
			wr_data.interval = (op_q == OP_SCHED_REP) ? delay_q : 16'd0;
			wr_data.remaining = (op_q == OP_SCHED_REP) ? rcount_q : 16'd1;
		end else if (state_q == S_UPD) begin
			wr_en = 1'b1;
			wr_data.remaining = limited ? newrm : rd_q.remaining;
			if (!dies) begin
				wr_data.due = upd_due[32] ? 32'hFFFFFFFF : upd_due[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= in_op;
			delay_q <= s_axis_tdata[34:19];
			rcount_q <= s_axis_tdata[50:35];
			tid_q <= s_axis_tdata[82:51];
			ev_q <= s_axis_tdata[98:83];
			pl_q <= s_axis_tdata[130:99];
		end
		if (state_q == S_RANK && valid_q[cidx]) begin
			order_q[rank[IDX_W-1:0]] <= cidx;
		end
		if (state_q == S_SINGLE && out_free && !full &&
			(op_q == OP_SCHED_ONCE || op_q == OP_SCHED_REP)) begin
			id_q[free_idx] <= next_id_q;
		end
		if (state_q == S_READ) begin
			cur_q <= rd_addr;
		end
		if (state_q == S_CHECK) begin
			dq_q <= clock_q - rd_q.due;
			rem_q <= '0;
			dcnt_q <= '0;
		end
		if (state_q == S_DIV) begin
			dq_q <= {dq_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], rem_ge};
			rem_q <= rem_ge ? (rem_sh - {1'b0, rd_q.interval}) : rem_sh;
			dcnt_q <= dcnt_q + 5'd1;
		end
		if (state_q == S_CHECK) begin
			new_q <= '{status: ST_OK, result_id: id_q[cur_q],
				fired_event: rd_q.event_code, fired_payload: rd_q.payload,
				fire_count: 16'd1, present: 1'b0};
		end
		if (state_q == S_UPD) begin
			new_q.fire_count <= cnt16;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clock_q <= '0;
			next_id_q <= 32'd1;
			valid_q <= '0;
			paused_q <= '0;
			cnt_q <= '0;
			nvalid_q <= '0;
			hold_q <= '0;
			hold_v_q <= 1'b0;
			out_q <= '0;
			out_v_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_op == OP_ADVANCE) begin
							clock_q <= clk_sum[32] ? 32'hFFFFFFFF : clk_sum[31:0];
							nvalid_q <= CNT_W'($countones(valid_q));
							cnt_q <= '0;
							state_q <= S_RANK;
						end else begin
							state_q <= S_SINGLE;
						end
					end
				end
				S_SINGLE: begin
					if (out_free) begin
						out_q <= single_res;
						out_last_q <= 1'b1;
						state_q <= S_IDLE;
						case (op_q)
							OP_SCHED_ONCE, OP_SCHED_REP: begin
								if (!full) begin
									valid_q[free_idx] <= 1'b1;
									paused_q[free_idx] <= 1'b0;
									next_id_q <= (nid_inc == 32'd0) ? 32'd1 : nid_inc;
								end
							end
							OP_CANCEL: begin
								if (found) begin
									valid_q[hit_idx] <= 1'b0;
								end
							end
							OP_PAUSE: begin
								if (found) begin
									paused_q[hit_idx] <= 1'b1;
								end
							end
							OP_RESUME: begin
								if (found) begin
									paused_q[hit_idx] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RANK: begin
					if (cnt_q == CNT_W'(DEPTH - 1)) begin
						cnt_q <= '0;
						state_q <= S_READ;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_READ: begin
					state_q <= (cnt_q == nvalid_q) ? S_FINISH : S_CHECK;
				end
				S_CHECK: begin
					if (paused_q[cur_q] || rd_q.event_code == 16'd0 || !due_ok) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_READ;
					end else if (!rd_q.repeating || rd_q.interval == 16'd0) begin
						valid_q[cur_q] <= 1'b0;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dcnt_q == 5'd31) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (dies) begin
						valid_q[cur_q] <= 1'b0;
					end
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!hold_v_q) begin
						hold_q <= new_q;
						hold_v_q <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_READ;
					end else if (out_free) begin
						out_q <= hold_q;
						out_last_q <= 1'b0;
						hold_q <= new_q;
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_q <= hold_v_q ? hold_q : '0;
						out_last_q <= 1'b1;
						hold_v_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DETT_ASSERT_SAME(a_id_nonzero, 1'b1, next_id_q != 32'd0)
	`DETT_ASSERT_NEXT(a_clock_mono, 1'b1, clock_q >= $past(clock_q))
	`DETT_ASSERT_SAME(a_walk_live, state_q == S_CHECK, valid_q[cur_q] && cnt_q < nvalid_q)
	`DETT_ASSERT_SAME(a_hold_walk, hold_v_q, state_q != S_IDLE && state_q != S_SINGLE)
endmodule
